// File: rtl/uudec_pkg.sv
// uudec_pkg: item types, decoder constants and controller/datapath interface structs
package uudec_pkg;

	localparam int SEXTET_W = 6;
	localparam logic [SEXTET_W-1:0] CODE_BIAS = 6'd32;

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} out_item_t;

	typedef struct packed {
		logic load_count;
		logic feed;
		logic zero_val;
		logic clear;
	} uudec_cmd_t;

	typedef struct packed {
		logic in_line;
		logic left_zero;
		logic slot_free;
	} uudec_sts_t;

	function automatic logic [SEXTET_W-1:0] to_sextet(input logic [7:0] code);
		to_sextet = code[SEXTET_W-1:0] - CODE_BIAS;
	endfunction

endpackage

// File: rtl/uudec_ctrl.sv
// uudec_ctrl: line controller, sequences character intake and the early-end flush
module uudec_ctrl import uudec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       line_end,
	output logic       in_ready,
	input  uudec_sts_t sts,
	output uudec_cmd_t cmd
);

	localparam logic ST_ACCEPT = 1'b0;
	localparam logic ST_FLUSH  = 1'b1;

	logic state_q;
	logic state_d;
	logic take;

	assign in_ready = (state_q == ST_ACCEPT) && sts.slot_free;
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_ACCEPT: begin
				if (take) begin
					cmd.load_count = !sts.in_line;
					cmd.feed       = sts.in_line;
					if (line_end) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.left_zero) begin
					cmd.clear = 1'b1;
					state_d   = ST_ACCEPT;
				end else if (sts.slot_free) begin
					cmd.feed     = 1'b1;
					cmd.zero_val = 1'b1;
				end
			end
			default: begin
				state_d = ST_ACCEPT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/uudec_dpath.sv
// uudec_dpath: line state, sextet assembly and the output item register
module uudec_dpath import uudec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_item,
	input  uudec_cmd_t cmd,
	output uudec_sts_t sts,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item
);

	logic                in_line_q;
	logic [5:0]          bytes_left_q;
	logic [1:0]          group_pos_q;
	logic [SEXTET_W-1:0] prev_sextet_q;
	logic                out_valid_q;
	out_item_t           out_item_q;

	logic [SEXTET_W-1:0] v;
	logic [7:0]          byte_val;
	logic [5:0]          left_dec;
	logic                active;
	logic                emit;

	assign v        = cmd.zero_val ? '0 : to_sextet(in_item.char_code);
	assign left_dec = bytes_left_q - 6'd1;
	assign active   = cmd.feed && (bytes_left_q != '0);
	assign emit     = active && (group_pos_q != 2'd0);

	always_comb begin
		unique case (group_pos_q)
			2'd1:    byte_val = {prev_sextet_q, v[5:4]};
			2'd2:    byte_val = {prev_sextet_q[3:0], v[5:2]};
			2'd3:    byte_val = {prev_sextet_q[1:0], v};
			default: byte_val = '0;
		endcase
	end

	assign sts.in_line   = in_line_q;
	assign sts.left_zero = (bytes_left_q == '0);
	assign sts.slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q     <= 1'b0;
			bytes_left_q  <= '0;
			group_pos_q   <= '0;
			prev_sextet_q <= '0;
		end else if (cmd.clear) begin
			in_line_q     <= 1'b0;
			bytes_left_q  <= '0;
			group_pos_q   <= '0;
			prev_sextet_q <= '0;
		end else if (cmd.load_count) begin
			in_line_q     <= 1'b1;
			bytes_left_q  <= v;
			group_pos_q   <= '0;
			prev_sextet_q <= '0;
		end else if (active) begin
			prev_sextet_q <= v;
			group_pos_q   <= group_pos_q + 2'd1;
			if (emit) begin
				bytes_left_q <= left_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q.data_byte <= byte_val;
			out_item_q.last_byte <= (left_dec == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_feed_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.feed |-> sts.slot_free)
		else $error("feed issued while output item still held");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_line_q |-> (bytes_left_q == '0) && (group_pos_q == 2'd0))
		else $error("line state not clear outside a line");

	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_count |-> !in_line_q)
		else $error("count loaded inside a line");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("emitted byte not presented");

endmodule

// File: rtl/uudecode_line_stream.sv
// uudecode_line_stream: top level of the streaming uudecode line decoder
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_item  (char_code, line_end)
//   out     | output    | out_valid / out_ready | out_item (data_byte, last_byte)
//
// one character per cycle while the output register is free or being drained
// a line end with bytes still owed leads into a flush that feeds zero sextets until
// the count is spent; every line end then passes a clear step that resets the line state
// intake is held during the flush and the clear cycle
// arst_n clears the controller, line state and output valid
// out_ready low stalls intake once the output register holds an item
module uudecode_line_stream import uudec_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	uudec_cmd_t cmd;
	uudec_sts_t sts;

	uudec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.line_end (in_item.line_end),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	uudec_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
